### hw/rtl/sld_pkg.sv
// Shared types, constants and the gear lookup for the shift lever intent decoder.
// No dependencies; used by sld_step.sv and shift_lever_intent_decoder_top.sv.
package sld_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int THRESH_WIDTH = 16;
    // Compare width covers both the counter and the threshold register.
    localparam int CMP_WIDTH    = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(10);

    // Lever flag bits
    localparam int FLAG_CENTRE_BIT = 0;
    localparam int FLAG_FWD_BIT    = 1;
    localparam int FLAG_BACK_BIT   = 2;

    localparam logic [2:0] FLAGS_NONE   = 3'b000;
    localparam logic [2:0] FLAGS_CENTRE = 3'b001;
    localparam logic [2:0] FLAGS_FWD    = 3'b010;
    localparam logic [2:0] FLAGS_BACK   = 3'b100;

    // Gear codes
    localparam logic [1:0] GEAR_NONE = 2'd0;
    localparam logic [1:0] GEAR_N    = 2'd1;
    localparam logic [1:0] GEAR_R    = 2'd2;
    localparam logic [1:0] GEAR_D    = 2'd3;

    // Lever state codes
    localparam logic [1:0] LEVER_UNKNOWN = 2'd0;
    localparam logic [1:0] LEVER_CENTRE  = 2'd1;
    localparam logic [1:0] LEVER_FWD     = 2'd2;
    localparam logic [1:0] LEVER_BACK    = 2'd3;

    // Transmission positions
    localparam logic [2:0] POS_P = 3'd0;
    localparam logic [2:0] POS_R = 3'd1;
    localparam logic [2:0] POS_N = 3'd2;
    localparam logic [2:0] POS_D = 3'd3;

    typedef enum logic [1:0] {
        PHASE_RELEASE = 2'd0,
        PHASE_NEW     = 2'd1,
        PHASE_FINISH  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] hall_levels;
        logic [2:0] current_position;
    } in_item_t;

    typedef struct packed {
        logic [1:0] target_gear;
        logic       shift_locked;
        logic [1:0] lever_state;
        logic       move_taken;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] hold_count;
        phase_t                 move_phase;
        logic [2:0]             lever_flags;
        logic                   lock_flag;
        logic [1:0]             gear_request;
    } lever_state_t;

    // Target gear for a mapped position and push direction.
    function automatic logic [1:0] gear_lookup(input logic [2:0] pos, input logic back);
        logic [1:0] gear;
        begin
            gear = GEAR_NONE;
            unique case (pos)
                POS_P:   gear = GEAR_N;
                POS_R:   gear = back ? GEAR_D : GEAR_N;
                POS_N:   gear = back ? GEAR_D : GEAR_R;
                POS_D:   gear = back ? GEAR_N : GEAR_R;
                default: gear = GEAR_NONE;
            endcase
            return gear;
        end
    endfunction

endpackage

### hw/rtl/sld_step.sv
// Next-state and result logic for one sensor tick of the shift lever decoder.
// Depends on sld_pkg for the state, item types and the gear lookup.
module sld_step (
    input  sld_pkg::lever_state_t                 cur,
    input  sld_pkg::in_item_t                     item,
    input  logic [sld_pkg::THRESH_WIDTH-1:0]      threshold,
    output sld_pkg::lever_state_t                 nxt,
    output sld_pkg::out_item_t                    result
);

    logic [7:0]                      h;
    logic                            h12_low;
    logic                            h34_low;
    logic                            h34_high;
    logic                            h78_low;
    logic                            push_back;
    logic                            push_fwd;
    logic [sld_pkg::COUNT_WIDTH-1:0] count_inc;
    logic [2:0]                      dir_flags;

    assign h        = item.hall_levels;
    assign h12_low  = !h[0] || !h[1];
    assign h34_low  = !h[2] || !h[3];
    assign h34_high = h[2] || h[3];
    assign h78_low  = !h[6] || !h[7];
    assign push_back = h78_low && !h[4];
    assign push_fwd  = h78_low && !h[5];

    // Saturating increment
    assign count_inc = (&cur.hold_count) ? cur.hold_count
                                         : cur.hold_count + sld_pkg::COUNT_WIDTH'(1);
    // Back push wins over forward push
    assign dir_flags = push_back ? sld_pkg::FLAGS_BACK : sld_pkg::FLAGS_FWD;

    always_comb
    begin
        nxt = cur;
        priority if (h12_low && h34_high)
        begin
            nxt.lock_flag = 1'b1;
        end
        else if (h34_low)
        begin
            if (push_back || push_fwd)
            begin
                nxt.hold_count = count_inc;
                if (sld_pkg::CMP_WIDTH'(count_inc) > sld_pkg::CMP_WIDTH'(threshold))
                begin
                    if (cur.move_phase == sld_pkg::PHASE_RELEASE)
                    begin
                        nxt.move_phase  = sld_pkg::PHASE_NEW;
                        nxt.lever_flags = dir_flags;
                    end
                    nxt.lock_flag = 1'b0;
                end
            end
            else
            begin
                nxt.hold_count  = '0;
                nxt.move_phase  = sld_pkg::PHASE_RELEASE;
                nxt.lever_flags = sld_pkg::FLAGS_CENTRE;
                nxt.lock_flag   = 1'b1;
            end
        end
        else
        begin
            // H3 and H4 both absent: hold every field
            nxt = cur;
        end

        // Judge a freshly accepted move in the same tick
        if (nxt.move_phase == sld_pkg::PHASE_NEW)
        begin
            nxt.move_phase = sld_pkg::PHASE_FINISH;
            if (!nxt.lock_flag && !item.current_position[2])
            begin
                if (nxt.lever_flags[sld_pkg::FLAG_FWD_BIT])
                    nxt.gear_request = sld_pkg::gear_lookup(item.current_position, 1'b0);
                else if (nxt.lever_flags[sld_pkg::FLAG_BACK_BIT])
                    nxt.gear_request = sld_pkg::gear_lookup(item.current_position, 1'b1);
            end
        end
    end

    always_comb
    begin
        result.target_gear  = nxt.gear_request;
        result.shift_locked = nxt.lock_flag;
        result.move_taken   = (nxt.move_phase == sld_pkg::PHASE_FINISH);
        priority if (nxt.lever_flags[sld_pkg::FLAG_CENTRE_BIT])
            result.lever_state = sld_pkg::LEVER_CENTRE;
        else if (nxt.lever_flags[sld_pkg::FLAG_FWD_BIT])
            result.lever_state = sld_pkg::LEVER_FWD;
        else if (nxt.lever_flags[sld_pkg::FLAG_BACK_BIT])
            result.lever_state = sld_pkg::LEVER_BACK;
        else
            result.lever_state = sld_pkg::LEVER_UNKNOWN;
    end

endmodule

### hw/rtl/shift_lever_intent_decoder_top.sv
// Top level of the shift lever intent decoder: input register, state, result register.
// Depends on sld_pkg and sld_step.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   in       | in_valid/in_stall  | in_data  (sld_pkg::in_item_t)
//   out      | out_valid/out_stall| out_data (sld_pkg::out_item_t)
//   cfg      | cfg_we             | cfg_wdata (debounce threshold)
//
// Each tick passes through the input register, then through the step logic into
// the result register and the lever state.
// One transaction is accepted per cycle while the output side keeps up.
// rst_n clears the lever state, loads threshold 10 and empties both registers.
// A stalled result holds the result register and, once the input register is
// also full, raises in_stall.
module shift_lever_intent_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sld_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sld_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [sld_pkg::THRESH_WIDTH-1:0]  cfg_wdata
);

    logic [sld_pkg::THRESH_WIDTH-1:0] threshold_reg;
    logic                             s1_valid_reg;
    sld_pkg::in_item_t                s1_item_reg;
    logic                             out_valid_reg;
    sld_pkg::out_item_t               out_item_reg;
    sld_pkg::lever_state_t            state_reg;
    sld_pkg::lever_state_t            state_next;
    sld_pkg::out_item_t               result_next;
    logic                             s1_adv;
    logic                             in_take;

    sld_step u_step (
        .cur       (state_reg),
        .item      (s1_item_reg),
        .threshold (threshold_reg),
        .nxt       (state_next),
        .result    (result_next)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg          <= sld_pkg::THRESH_RESET;
            s1_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.hold_count   <= '0;
            state_reg.move_phase   <= sld_pkg::PHASE_RELEASE;
            state_reg.lever_flags  <= sld_pkg::FLAGS_NONE;
            state_reg.lock_flag    <= 1'b1;
            state_reg.gear_request <= sld_pkg::GEAR_NONE;
        end
        else
        begin
            if (cfg_we)
                threshold_reg <= cfg_wdata;
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (s1_adv)
            out_item_reg <= result_next;
    end

`ifndef SYNTHESIS
    // A new move is always judged in the tick that accepts it.
    a_no_stored_new_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.move_phase != sld_pkg::PHASE_NEW)
        else $error("move phase left in new state");

    // A taken move always carries a push direction.
    a_finish_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.move_phase == sld_pkg::PHASE_FINISH |->
        (state_reg.lever_flags == sld_pkg::FLAGS_FWD ||
         state_reg.lever_flags == sld_pkg::FLAGS_BACK))
        else $error("finished move without push direction");

    // An item leaving the input register lands in the result register.
    a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced item lost");

    // The state only changes when an item advances.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(state_reg))
        else $error("lever state changed without an item");
`endif

endmodule

### bench/shift_lever_intent_decoder_top_test.sv
// Self-checking bench for shift_lever_intent_decoder_top: drives hall sensor ticks and
// threshold writes, predicts every lever report and compares it field by field.
// Depends on sld_pkg and the decoder RTL; nothing else.
module shift_lever_intent_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_FULL = '1;

    // What one tick of sensor levels asks for; decode_tick ranks lock, idle, back, forward, centre.
    typedef enum int {
        TICK_IDLE,
        TICK_LOCK,
        TICK_CENTRE,
        TICK_FWD,
        TICK_BACK
    } tick_kind_t;

    class lever_intent_tracker;
        logic [THRESH_WIDTH-1:0] threshold;
        logic [COUNT_WIDTH-1:0]  hold_count;
        phase_t                  phase;
        logic [2:0]              flags;
        logic                    lock;
        logic [1:0]              gear;
        logic [1:0]              gear_map [4][2];
        out_item_t               pending_reports [$];
        int unsigned             mismatches;

        function new();
            threshold  = THRESH_WIDTH'(10);
            hold_count = '0;
            phase      = PHASE_RELEASE;
            flags      = FLAGS_NONE;
            lock       = 1'b1;
            gear       = GEAR_NONE;
            mismatches = 0;
            // rows P, R, N, D; columns forward, back
            gear_map = '{'{GEAR_N, GEAR_N}, '{GEAR_N, GEAR_D},
                         '{GEAR_R, GEAR_D}, '{GEAR_R, GEAR_N}};
        endfunction

        static function tick_kind_t decode_tick(logic [7:0] h);
            logic h12_low;
            logic h34_low;
            logic h34_high;
            logic h78_low;
            h12_low  = !h[0] || !h[1];
            h34_low  = !h[2] || !h[3];
            h34_high = h[2] || h[3];
            h78_low  = !h[6] || !h[7];
            if (h12_low && h34_high)
                return TICK_LOCK;
            if (!h34_low)
                return TICK_IDLE;
            if (h78_low && !h[4])
                return TICK_BACK;
            if (h78_low && !h[5])
                return TICK_FWD;
            return TICK_CENTRE;
        endfunction

        function void note_tick(in_item_t item);
            tick_kind_t kind;
            out_item_t  report;
            kind = decode_tick(item.hall_levels);
            case (kind)
                TICK_LOCK:
                    lock = 1'b1;
                TICK_FWD, TICK_BACK:
                begin
                    if (hold_count != COUNT_FULL)
                        hold_count = hold_count + 1'b1;
                    if (hold_count > threshold)
                    begin
                        if (phase == PHASE_RELEASE)
                        begin
                            phase = PHASE_NEW;
                            flags = (kind == TICK_BACK) ? FLAGS_BACK : FLAGS_FWD;
                        end
                        lock = 1'b0;
                    end
                end
                TICK_CENTRE:
                begin
                    hold_count = '0;
                    phase      = PHASE_RELEASE;
                    flags      = FLAGS_CENTRE;
                    lock       = 1'b1;
                end
                default: ;
            endcase

            // A fresh move is judged at once; unmapped positions keep the old gear.
            if (phase == PHASE_NEW)
            begin
                phase = PHASE_FINISH;
                if (!lock && item.current_position <= POS_D)
                begin
                    if (flags[FLAG_FWD_BIT])
                        gear = gear_map[item.current_position[1:0]][0];
                    else if (flags[FLAG_BACK_BIT])
                        gear = gear_map[item.current_position[1:0]][1];
                end
            end

            report.target_gear  = gear;
            report.shift_locked = lock;
            report.lever_state  = flags[FLAG_CENTRE_BIT] ? LEVER_CENTRE :
                                  flags[FLAG_FWD_BIT]    ? LEVER_FWD    :
                                  flags[FLAG_BACK_BIT]   ? LEVER_BACK   : LEVER_UNKNOWN;
            report.move_taken   = (phase == PHASE_FINISH);
            pending_reports.push_back(report);
        endfunction

        function void compare_field(string field, logic [1:0] want, logic [1:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: result %p with none expected", $time, got);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("target_gear", want.target_gear, got.target_gear);
            compare_field("shift_locked", want.shift_locked, got.shift_locked);
            compare_field("lever_state", want.lever_state, got.lever_state);
            compare_field("move_taken", want.move_taken, got.move_taken);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    in_item_t                in_data;
    logic                    out_valid;
    logic                    out_stall;
    out_item_t               out_data;
    logic                    cfg_we;
    logic [THRESH_WIDTH-1:0] cfg_wdata;

    lever_intent_tracker tracker;
    bit                  calm;
    bit                  hold_off_req;
    int unsigned         ticks_sent;

    shift_lever_intent_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] hall_of(tick_kind_t kind);
        logic [7:0] h;
        do
            h = 8'($urandom);
        while (lever_intent_tracker::decode_tick(h) != kind);
        return h;
    endfunction

    function automatic logic [2:0] pick_position();
        if ($urandom_range(0, 7) == 0)
            return 3'($urandom_range(4, 7));
        return 3'($urandom_range(0, 3));
    endfunction

    task automatic idle_input(input int cycles);
        in_valid                 <= 1'b0;
        in_data.hall_levels      <= 8'($urandom);
        in_data.current_position <= 3'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input in_item_t item);
        bit taken;
        if (!calm && $urandom_range(0, 11) == 0)
            idle_input($urandom_range(1, 19));
        in_valid <= 1'b1;
        in_data  <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
            if (taken)
                tracker.note_tick(item);
            @(negedge clk);
        end
        ticks_sent++;
    endtask

    task automatic send_tick(input tick_kind_t kind, input logic [2:0] position);
        in_item_t item;
        item.hall_levels      = hall_of(kind);
        item.current_position = position;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.threshold = value;
    endtask

    // Mostly centre-then-push gestures with random content, plus noise and broken pushes.
    task automatic run_phase(input int count);
        int unsigned target;
        int          len;
        tick_kind_t  dir;
        in_item_t    noise;
        target = ticks_sent + count;
        while (ticks_sent < target)
        begin
            dir = $urandom_range(0, 1) ? TICK_FWD : TICK_BACK;
            case ($urandom_range(0, 9))
                7:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        noise.hall_levels      = 8'($urandom);
                        noise.current_position = 3'($urandom);
                        send_item(noise);
                    end
                end
                8:
                    send_tick($urandom_range(0, 1) ? TICK_IDLE : TICK_LOCK, pick_position());
                9:
                    repeat ($urandom_range(1, 3)) send_tick(dir, pick_position());
                default:
                begin
                    repeat ($urandom_range(1, 2)) send_tick(TICK_CENTRE, pick_position());
                    if ($urandom_range(0, 5) == 0)
                        len = $urandom_range(1, int'(tracker.threshold) + 1);
                    else
                        len = int'(tracker.threshold) + 1 + $urandom_range(0, 3);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_tick(TICK_LOCK, pick_position());
                        send_tick(dir, pick_position());
                    end
                end
            endcase
        end
    endtask

    initial
    begin : result_side
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // hold off long enough for the block to fill and stall its input
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        ticks_sent   = 0;
        tracker      = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset threshold: only the eleventh forward tick is taken as a move.
        send_tick(TICK_IDLE, POS_P);
        send_tick(TICK_LOCK, POS_P);
        send_tick(TICK_CENTRE, POS_P);
        repeat (11) send_tick(TICK_FWD, POS_P);

        // Zero threshold: each push that follows a centre tick is taken on its first tick.
        write_threshold('0);
        send_tick(TICK_BACK, POS_R);
        send_tick(TICK_CENTRE, POS_R);
        send_tick(TICK_FWD, POS_N);
        send_tick(TICK_CENTRE, POS_N);
        send_tick(TICK_BACK, POS_D);
        send_tick(TICK_CENTRE, POS_D);
        send_tick(TICK_FWD, 3'd6);
        send_tick(TICK_CENTRE, 3'd7);
        send_tick(TICK_BACK, POS_P);
        send_tick(TICK_FWD, POS_D);

        write_threshold(THRESH_WIDTH'(1));
        run_phase(150);
        write_threshold(THRESH_WIDTH'(3));
        run_phase(50);
        hold_off_req = 1'b1;
        run_phase(100);
        write_threshold(THRESH_WIDTH'($urandom_range(0, 5)));
        run_phase(70);
        wait_drained();
        run_phase(80);
        write_threshold(THRESH_WIDTH'(2));
        run_phase(150);
        write_threshold('0);
        run_phase(150);

        // Last stretch runs with no idling on either side.
        calm = 1'b1;
        write_threshold(THRESH_WIDTH'($urandom_range(0, 4)));
        run_phase(200);
        wait_drained();

        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/sld_pkg.sv
hw/rtl/sld_step.sv
hw/rtl/shift_lever_intent_decoder_top.sv
bench/shift_lever_intent_decoder_top_test.sv
